FILE: sv/accel_lever_arm_compensation_core_defines.svh
// ----------------------------------------------------------------------------
// accel_lever_arm_compensation_core_defines
// Assertion helpers shared by the lever-arm compensation block.
// ----------------------------------------------------------------------------
`ifndef ACCEL_LEVER_ARM_COMPENSATION_CORE_DEFINES_SVH
`define ACCEL_LEVER_ARM_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ALAC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("alac check failed");

// Next-cycle implication, disabled during reset.
`define ALAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alac check failed");

`endif

FILE: sv/alac_pkg.sv
// ----------------------------------------------------------------------------
// alac_pkg
// Types and constants of the accelerometer lever-arm compensation block.
// ----------------------------------------------------------------------------
package alac_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned RateW    = 32;
  localparam int unsigned ForceW   = 32;
  localparam int unsigned ArmW     = 16;
  localparam int unsigned CfgW     = 48;
  localparam int unsigned NumW     = 41;  // (rate difference) * 256
  localparam int unsigned DwW      = 40;  // angular acceleration, Q.8
  localparam int unsigned MinStep  = 4;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusFirst   = 2'd2;
  localparam logic [1:0] StatusShort   = 2'd3;

  localparam logic [1:0] CfgArmX = 2'd0;
  localparam logic [1:0] CfgArmY = 2'd1;
  localparam logic [1:0] CfgArmZ = 2'd2;

  typedef struct packed {
    logic [47:0]        timestamp;
    logic               sample_valid;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
    logic signed [31:0] out_force_z;
    logic [1:0]         status;
  } out_t;

endpackage

FILE: sv/accel_lever_arm_compensation_core.sv
// ----------------------------------------------------------------------------
// accel_lever_arm_compensation_core
// Removes proof-mass lever-arm terms from IMU specific force samples.
// ----------------------------------------------------------------------------
// One request at a time. A corrected sample passes through the three serial
// divider lanes that form angular acceleration, then the correction lanes that
// step through their shared multipliers, then the hand-off to the output
// register. Pass-through samples (invalid, first, short step) skip both lanes.
// The output register frees the input side, so the next request is taken
// while a result still waits downstream. Lever arms are written through the
// config port (index 0..2, other indexes ignored) and reset to zero.
module accel_lever_arm_compensation_core import alac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StCorr = 2'd2;
  localparam logic [1:0] StPush = 2'd3;

  logic [1:0]              state_q;
  logic                    have_q;
  logic [TimeW-1:0]        prev_time_q;
  logic signed [RateW-1:0] prev_rate_q [NumAxes];
  logic [CfgW-1:0]         arm_q [NumAxes];
  in_t                     in_q;
  out_t                    res_q, out_q;
  logic                    out_valid_q;

  logic                     in_acc, out_free;
  logic [TimeW:0]           dt;
  logic                     short_step;
  logic signed [RateW-1:0]  w   [NumAxes];
  logic signed [RateW-1:0]  wq  [NumAxes];
  logic signed [ForceW-1:0] fq  [NumAxes];
  logic signed [NumW-1:0]   num [NumAxes];
  logic                     div_start, corr_start;
  logic [NumAxes-1:0]       div_done, corr_done;
  logic signed [DwW-1:0]    dw  [NumAxes];
  logic signed [ForceW-1:0] lane_res [NumAxes];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  assign w[0]  = in_data_i.rate_x;
  assign w[1]  = in_data_i.rate_y;
  assign w[2]  = in_data_i.rate_z;
  assign wq[0] = in_q.rate_x;
  assign wq[1] = in_q.rate_y;
  assign wq[2] = in_q.rate_z;
  assign fq[0] = in_q.force_x;
  assign fq[1] = in_q.force_y;
  assign fq[2] = in_q.force_z;

  assign dt = {1'b0, in_data_i.timestamp} - {1'b0, prev_time_q};
  assign short_step = dt[TimeW] || (dt[TimeW-1:2] == '0);
  assign div_start = in_acc && in_data_i.sample_valid && have_q && !short_step;
  assign corr_start = (state_q == StDiv) && div_done[0];

  for (genvar k = 0; k < NumAxes; k++) begin : g_lane
    localparam int unsigned B = (k + 1) % NumAxes;
    localparam int unsigned C = (k + 2) % NumAxes;

    assign num[k] = ((NumW)'(w[k]) - (NumW)'(prev_rate_q[k])) <<< 8;

    alac_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(div_start),
      .num_i  (num[k]),
      .den_i  (dt[TimeW-1:0]),
      .done_o (div_done[k]),
      .dw_o   (dw[k])
    );

    alac_corr u_corr (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .start_i(corr_start),
      .wa_i   (wq[k]),
      .wb_i   (wq[B]),
      .wc_i   (wq[C]),
      .force_i(fq[k]),
      .ra_i   (arm_q[k][ArmW*k +: ArmW]),
      .rb_i   (arm_q[k][ArmW*B +: ArmW]),
      .rc_i   (arm_q[k][ArmW*C +: ArmW]),
      .dwb_i  (dw[B]),
      .dwc_i  (dw[C]),
      .done_o (corr_done[k]),
      .res_o  (lane_res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      have_q      <= 1'b0;
      prev_time_q <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NumAxes; k++) begin
        prev_rate_q[k] <= '0;
        arm_q[k]       <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgArmX: arm_q[0] <= cfg_data_i;
          CfgArmY: arm_q[1] <= cfg_data_i;
          CfgArmZ: arm_q[2] <= cfg_data_i;
          default: begin end
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (!in_data_i.sample_valid) begin
              state_q <= StPush;
            end else if (!have_q) begin
              have_q      <= 1'b1;
              prev_time_q <= in_data_i.timestamp;
              for (int k = 0; k < NumAxes; k++) prev_rate_q[k] <= w[k];
              state_q <= StPush;
            end else begin
              prev_time_q <= in_data_i.timestamp;
              if (short_step) begin
                state_q <= StPush;
              end else begin
                for (int k = 0; k < NumAxes; k++) prev_rate_q[k] <= w[k];
                state_q <= StDiv;
              end
            end
          end
        end
        StDiv:  if (div_done[0]) state_q <= StCorr;
        StCorr: if (corr_done[0]) state_q <= StPush;
        StPush: if (out_free) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      if (state_q == StPush && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
      res_q.out_force_x <= in_data_i.force_x;
      res_q.out_force_y <= in_data_i.force_y;
      res_q.out_force_z <= in_data_i.force_z;
      if (!in_data_i.sample_valid) begin
        res_q.status <= StatusInvalid;
      end else if (!have_q) begin
        res_q.status <= StatusFirst;
      end else if (short_step) begin
        res_q.status <= StatusShort;
      end else begin
        res_q.status <= StatusOk;
      end
    end else if (state_q == StCorr && corr_done[0]) begin
      res_q.out_force_x <= lane_res[0];
      res_q.out_force_y <= lane_res[1];
      res_q.out_force_z <= lane_res[2];
    end
    if (state_q == StPush && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "accel_lever_arm_compensation_core_defines.svh"

  `ALAC_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != StIdle)
  `ALAC_ASSERT_NOW(a_corr_done_in_corr, corr_done[0], state_q == StCorr)
  `ALAC_ASSERT_NEXT(a_load_from_push, state_q == StPush && out_free, out_valid_q)
  `ALAC_ASSERT_NOW(a_div_only_idle, div_start, state_q == StIdle)

endmodule

FILE: sv/alac_div.sv
// ----------------------------------------------------------------------------
// alac_div
// Serial signed divider lane: rate difference over time step, one bit a cycle.
// ----------------------------------------------------------------------------
module alac_div import alac_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [TimeW-1:0]       den_i,
  output logic                   done_o,
  output logic signed [DwW-1:0]  dw_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [TimeW:0]   rem_q, rem_d;
  logic [NumW-1:0]  quo_q, quo_d;
  logic [TimeW-1:0] den_q, den_d;
  logic [TimeW:0]   trial;
  logic [NumW:0]    signed_quo;

  assign trial = {rem_q[TimeW-1:0], quo_q[NumW-1]};
  assign signed_quo = neg_q ? ({(NumW+1){1'b0}} - {1'b0, quo_q}) : {1'b0, quo_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = num_i[NumW-1];
      rem_d  = '0;
      quo_d  = num_i[NumW-1] ? ({NumW{1'b0}} - num_i) : num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign dw_o   = signed_quo[DwW-1:0];

endmodule

FILE: sv/alac_corr.sv
// ----------------------------------------------------------------------------
// alac_corr
// Correction lane for one force axis: centripetal and tangential terms merged
// with the angular accelerations from the other lanes, one product a step.
// ----------------------------------------------------------------------------
module alac_corr import alac_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [RateW-1:0]  wa_i,
  input  logic signed [RateW-1:0]  wb_i,
  input  logic signed [RateW-1:0]  wc_i,
  input  logic signed [ForceW-1:0] force_i,
  input  logic signed [ArmW-1:0]   ra_i,
  input  logic signed [ArmW-1:0]   rb_i,
  input  logic signed [ArmW-1:0]   rc_i,
  input  logic signed [DwW-1:0]    dwb_i,
  input  logic signed [DwW-1:0]    dwc_i,
  output logic                     done_o,
  output logic signed [ForceW-1:0] res_o
);

  localparam logic [3:0] StSqB  = 4'd0;
  localparam logic [3:0] StSqC  = 4'd1;
  localparam logic [3:0] StPab  = 4'd2;
  localparam logic [3:0] StPac  = 4'd3;
  localparam logic [3:0] StMSq  = 4'd4;
  localparam logic [3:0] StMPab = 4'd5;
  localparam logic [3:0] StMPac = 4'd6;
  localparam logic [3:0] StMDwb = 4'd7;
  localparam logic [3:0] StMDwc = 4'd8;
  localparam logic [3:0] StFin  = 4'd9;

  localparam int unsigned OpW  = 41;
  localparam int unsigned AccW = 60;

  logic [3:0]               step_q;
  logic                     busy_q, done_q;
  logic signed [RateW:0]    sq_q;
  logic signed [RateW-1:0]  pab_q, pac_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [ForceW-1:0] res_q;

  logic signed [RateW-1:0]      ma, mb;
  logic signed [2*RateW-1:0]    rprod;
  logic signed [RateW-1:0]      rhi;
  logic signed [OpW-1:0]        aop;
  logic signed [ArmW-1:0]       arm;
  logic signed [OpW+ArmW-1:0]   aprod;
  logic signed [AccW-1:0]       aext;
  logic signed [AccW-15:0]      corr;
  logic signed [AccW-14:0]      diff;
  logic signed [ForceW-1:0]     sat;

  always_comb begin
    ma  = wb_i;
    mb  = wb_i;
    aop = OpW'(sq_q);
    arm = ra_i;
    unique case (step_q)
      StSqC:  begin ma = wc_i; mb = wc_i; end
      StPab:  begin ma = wa_i; mb = wb_i; end
      StPac:  begin ma = wa_i; mb = wc_i; end
      StMPab: begin aop = OpW'(pab_q); arm = rb_i; end
      StMPac: begin aop = OpW'(pac_q); arm = rc_i; end
      StMDwb: begin aop = OpW'(dwb_i); arm = rc_i; end
      StMDwc: begin aop = OpW'(dwc_i); arm = rb_i; end
      default: begin end
    endcase
  end

  assign rprod = ma * mb;
  assign rhi   = rprod[2*RateW-1:RateW];
  assign aprod = aop * arm;
  assign aext  = AccW'(aprod);
  assign corr  = acc_q[AccW-1:14];
  assign diff  = (AccW-13)'(force_i) - (AccW-13)'(corr);

  always_comb begin
    if (diff > (AccW-13)'(signed'({1'b0, {(ForceW-1){1'b1}}}))) begin
      sat = {1'b0, {(ForceW-1){1'b1}}};
    end else if (diff < -(AccW-13)'(signed'({1'b0, {(ForceW-1){1'b1}}})) - 1) begin
      sat = {1'b1, {(ForceW-1){1'b0}}};
    end else begin
      sat = diff[ForceW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StSqB;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= StSqB;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StFin) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      unique case (step_q)
        StSqB:  sq_q  <= (RateW+1)'(rhi);
        StSqC:  sq_q  <= sq_q + (RateW+1)'(rhi);
        StPab:  pab_q <= rhi;
        StPac:  pac_q <= rhi;
        StMSq:  acc_q <= -aext;
        StMDwc: acc_q <= acc_q - aext;
        StFin:  res_q <= sat;
        default: acc_q <= acc_q + aext;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: tb/accel_lever_arm_compensation_core_checker.sv
// ----------------------------------------------------------------------------
// accel_lever_arm_compensation_core_checker
// Watches the sample and result channels of the lever-arm compensation block,
// predicts each compensated force from its own copy of state and lever arms,
// and compares results in order.
// ----------------------------------------------------------------------------
module accel_lever_arm_compensation_core_checker import alac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0]        arm_reg [3];
  logic               have_prev;
  logic [47:0]        prev_time;
  logic signed [63:0] prev_rate [3];
  out_t               expected_forces [$];

  assign pending_o = expected_forces.size();

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] x, int s);
    return x >>> s;  // arithmetic shift floors
  endfunction

  function automatic logic signed [63:0] arm_of(int accel, int comp);
    logic signed [15:0] a;
    a = arm_reg[accel][16*comp +: 16];
    return 64'(a);
  endfunction

  function automatic out_t compensate(in_t s);
    out_t r;
    logic signed [63:0] w [3];
    logic signed [63:0] f [3];
    logic signed [63:0] dw [3];
    logic signed [63:0] res [3];
    logic signed [63:0] dt, sq, pab, pac, acc, v;
    int b, c;
    w[0] = 64'(s.rate_x); w[1] = 64'(s.rate_y); w[2] = 64'(s.rate_z);
    f[0] = 64'(s.force_x); f[1] = 64'(s.force_y); f[2] = 64'(s.force_z);
    for (int k = 0; k < 3; k++) res[k] = f[k];
    if (!s.sample_valid) begin
      r.status = StatusInvalid;
    end else if (!have_prev) begin
      have_prev = 1'b1;
      prev_time = s.timestamp;
      for (int k = 0; k < 3; k++) prev_rate[k] = w[k];
      r.status = StatusFirst;
    end else begin
      dt = $signed({16'd0, s.timestamp}) - $signed({16'd0, prev_time});
      prev_time = s.timestamp;
      if (dt < signed'(64'(MinStep))) begin
        r.status = StatusShort;
      end else begin
        for (int k = 0; k < 3; k++) begin
          dw[k] = ((w[k] - prev_rate[k]) * 256) / dt;
          prev_rate[k] = w[k];
        end
        for (int k = 0; k < 3; k++) begin
          b = (k + 1) % 3;
          c = (k + 2) % 3;
          sq  = floor_shift(w[b] * w[b], 32) + floor_shift(w[c] * w[c], 32);
          pab = floor_shift(w[k] * w[b], 32);
          pac = floor_shift(w[k] * w[c], 32);
          acc = -sq * arm_of(k, k) + pab * arm_of(k, b) + pac * arm_of(k, c)
                + dw[b] * arm_of(k, c) - dw[c] * arm_of(k, b);
          v = f[k] - floor_shift(acc, 14);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          else if (v < -64'sd2147483648) v = -64'sd2147483648;
          res[k] = v;
        end
        r.status = StatusOk;
      end
    end
    r.out_force_x = res[0][31:0];
    r.out_force_y = res[1][31:0];
    r.out_force_z = res[2][31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        arm_reg[k] = '0;
        prev_rate[k] = '0;
      end
      have_prev = 1'b0;
      prev_time = '0;
      err_count_o = 0;
      expected_forces.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= CfgArmZ)
        arm_reg[cfg_index_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        expected_forces.push_back(compensate(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data_i.status), 32'h0);
        end else begin
          want = expected_forces.pop_front();
          if (out_data_i.out_force_x !== want.out_force_x)
            report_mismatch("force_x", out_data_i.out_force_x, want.out_force_x);
          if (out_data_i.out_force_y !== want.out_force_y)
            report_mismatch("force_y", out_data_i.out_force_y, want.out_force_y);
          if (out_data_i.out_force_z !== want.out_force_z)
            report_mismatch("force_z", out_data_i.out_force_z, want.out_force_z);
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
        end
      end
    end
  end
endmodule

FILE: tb/accel_lever_arm_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// accel_lever_arm_compensation_core_tb
// Drives IMU samples and lever-arm writes into the compensation block with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module accel_lever_arm_compensation_core_tb;
  import alac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgArmX;
  logic [47:0] cfg_data_i = '0;
  int          err_count;
  int          pending;
  bit          hold_output = 1'b0;
  logic [47:0] sample_time = 48'd1000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  accel_lever_arm_compensation_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o,
    .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  accel_lever_arm_compensation_core_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 4000)) - 2000);
      3: return $urandom();
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_output = 1'b0;
      end
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_arm(logic [1:0] idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Keep valid high between back-to-back requests; drop it only for a gap.
  task automatic send_sample(in_t s, bit allow_gap);
    int n;
    n = allow_gap ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_rand(int step_kind, bit allow_gap);
    in_t s;
    case (step_kind)
      0: sample_time = sample_time + 48'($urandom_range(4, 2000));
      1: sample_time = sample_time + 48'($urandom_range(0, 3));
      2: sample_time = sample_time - 48'($urandom_range(1, 50));
      default: sample_time = {$urandom(), 16'($urandom())};
    endcase
    s.timestamp = sample_time;
    s.sample_valid = ($urandom_range(0, 9) != 0);
    s.rate_x = rand_word();
    s.rate_y = rand_word();
    s.rate_z = rand_word();
    s.force_x = rand_word();
    s.force_y = rand_word();
    s.force_z = rand_word();
    send_sample(s, allow_gap);
  endtask

  function automatic logic [47:0] rand_arm();
    logic [47:0] v;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: v[16*k +: 16] = 16'h7fff;
        1: v[16*k +: 16] = 16'h8000;
        default: v[16*k +: 16] = 16'($urandom());
      endcase
    end
    return v;
  endfunction

  initial begin
    in_t s;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_arm(CfgArmX, 48'h0100_ff00_0800);
    write_arm(CfgArmY, 48'h7fff_8000_0001);
    write_arm(CfgArmZ, 48'hc000_4000_ffff);
    write_arm(2'd3, 48'hffff_ffff_ffff);  // out-of-range index, dropped

    // Directed: invalid before first, first, normal, short, backward, zero, extremes.
    s = '0;
    s.timestamp = 48'd500;
    s.force_x = 32'sh7fffffff; s.force_y = 32'sh80000000; s.force_z = 32'sh1;
    send_sample(s, 0);
    s.sample_valid = 1'b1;
    s.rate_x = 32'sh01000000;
    send_sample(s, 0);
    s.timestamp = 48'd600; s.rate_x = 32'sh7fffffff; s.rate_y = 32'sh80000000;
    s.rate_z = 32'sh7fffffff;
    send_sample(s, 0);
    s.timestamp = 48'd603;
    send_sample(s, 0);
    s.timestamp = 48'd603;
    send_sample(s, 0);
    s.timestamp = 48'd500;
    send_sample(s, 0);
    s.timestamp = 48'd504; s.rate_x = 32'sh80000000; s.rate_y = 32'sh7fffffff;
    s.rate_z = 32'sh80000000;
    s.force_x = 32'sh80000000; s.force_y = 32'sh7fffffff;
    send_sample(s, 0);
    s.timestamp = 48'hffff_ffff_ffff;
    send_sample(s, 0);
    s.timestamp = 48'h0;
    send_sample(s, 0);
    s.timestamp = 48'h4; s.rate_x = 32'sh0; s.rate_y = 32'sh0; s.rate_z = 32'sh0;
    send_sample(s, 0);
    s.sample_valid = 1'b0; s.timestamp = 48'haaaa_5555_aaaa;
    s.rate_x = 32'shaaaaaaaa; s.rate_y = 32'sh55555555;
    s.force_x = 32'shffffffff; s.force_z = 32'sh55555555;
    send_sample(s, 0);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_arm(CfgArmX, '0); write_arm(CfgArmY, '0); write_arm(CfgArmZ, '0); end
        1: begin
          write_arm(CfgArmX, 48'h7fff_7fff_7fff);
          write_arm(CfgArmY, 48'h8000_8000_8000);
          write_arm(CfgArmZ, 48'h7fff_8000_7fff);
        end
        default: begin
          write_arm(CfgArmX, rand_arm());
          write_arm(CfgArmY, rand_arm());
          write_arm(CfgArmZ, rand_arm());
        end
      endcase
      if (phase == 2) begin
        hold_output = 1'b1;
        for (int i = 0; i < 20; i++) send_rand(0, 0);
      end
      for (int i = 0; i < 100; i++)
        send_rand(($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3), 1);
      drain();
    end

    if (err_count == 0) begin
      $display("accel_lever_arm_compensation_core_tb: clean");
    end else begin
      $display("accel_lever_arm_compensation_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("accel_lever_arm_compensation_core_tb: errors");
    $finish;
  end
endmodule
